@@ hw/rtl/rwg_pkg.sv @@
// Shared types and constants for the radial weight generator.
// No dependencies.
package rwg_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_BITS   = 13;
    localparam int HALF_BITS  = CFG_BITS - 1;
    localparam int DIFF_BITS  = (COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int NORM_BITS  = SQ_BITS + 1;
    localparam int REM_BITS   = NORM_BITS + 1;
    localparam int QUO_BITS   = 2 * FRAC_BITS + 2;
    localparam int DIV_CELLS  = 2 * FRAC_BITS + 1;
    localparam int ROOT_BITS  = FRAC_BITS + 1;
    localparam int SREM_BITS  = ROOT_BITS + 2;
    localparam int WEIGHT_BITS = FRAC_BITS + 2;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_SAT = WEIGHT_BITS'(1) << (FRAC_BITS + 1);

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_DISTANCE_MODE = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_column;
        logic [COORD_BITS-1:0] pixel_row;
    } coord_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic                   degenerate;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic                 deg;
        logic                 sat;
        logic [REM_BITS-1:0]  r;
        logic [NORM_BITS-1:0] m;
        logic [QUO_BITS-1:0]  q;
    } div_beat_t;

    typedef struct packed {
        logic                   valid;
        logic                   deg;
        logic                   sat;
        logic [QUO_BITS-1:0]    v;
        logic [ROOT_BITS-1:0]   root;
        logic [SREM_BITS-1:0]   rem;
        logic [WEIGHT_BITS-1:0] lin;
    } sqrt_beat_t;

endpackage

@@ hw/rtl/rwg_div_cell.sv @@
// One restoring-division cell: yields one quotient bit per beat.
// Depends on rwg_pkg.
module rwg_div_cell
    import rwg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_beat_t din,
    output div_beat_t dout
);

    div_beat_t           dout_reg;
    div_beat_t           dout_next;
    logic                ge;
    logic [REM_BITS-1:0] rs;

    always_comb
    begin
        ge        = din.r >= {1'b0, din.m};
        rs        = ge ? (din.r - {1'b0, din.m}) : din.r;
        dout_next = din;
        dout_next.r = {rs[REM_BITS-2:0], 1'b0};
        dout_next.q = {din.q[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

@@ hw/rtl/rwg_sqrt_cell.sv @@
// One digit-by-digit square root cell: yields one root bit per beat.
// Depends on rwg_pkg.
module rwg_sqrt_cell
    import rwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sqrt_beat_t din,
    output sqrt_beat_t dout
);

    sqrt_beat_t            dout_reg;
    sqrt_beat_t            dout_next;
    logic [SREM_BITS+1:0]  remx;
    logic [SREM_BITS+1:0]  trial;
    logic [SREM_BITS+1:0]  diff;
    logic                  ge;

    always_comb
    begin
        remx  = {din.rem, din.v[QUO_BITS-1:QUO_BITS-2]};
        trial = {2'b00, din.root, 2'b01};
        ge    = remx >= trial;
        diff  = ge ? (remx - trial) : remx;
        dout_next      = din;
        dout_next.v    = {din.v[QUO_BITS-3:0], 2'b00};
        dout_next.root = {din.root[ROOT_BITS-2:0], ge};
        dout_next.rem  = diff[SREM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

@@ hw/rtl/radial_weight_generator_core.sv @@
// Top level of the radial weight generator: front end, division and root chains.
// Depends on rwg_pkg, rwg_div_cell and rwg_sqrt_cell.
//
// Usage: raise start with a pixel coordinate on coord; a beat is taken at
// every rising edge with start high and busy low. busy stays low, so one
// coordinate may enter on every clock. Each beat leaves on result, marked
// by result_valid for one cycle, in input order.
// The pipeline holds 4 front-end stages (distances, squares, sums, range
// check), 2*FRAC_BITS+1 division cells, FRAC_BITS+1 root cells and one
// output register. Throughput is one beat per cycle; each cell of both
// chains holds one beat in flight.
// Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no beat is in flight.
// Reset empties the pipeline and loads width 640, height 480, mode 0.
// The receiver cannot stall; results are dropped if not taken.
module radial_weight_generator_core
    import rwg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  coord_t              coord,
    output logic                result_valid,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic                mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_BITS'(640);
            height_reg <= CFG_BITS'(480);
            mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_DISTANCE_MODE: mode_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic [DIFF_BITS-1:0] cx;
    logic [DIFF_BITS-1:0] cy;
    logic [DIFF_BITS-1:0] px;
    logic [DIFF_BITS-1:0] py;

    assign cx = DIFF_BITS'(width_reg[CFG_BITS-1:1]);
    assign cy = DIFF_BITS'(height_reg[CFG_BITS-1:1]);
    assign px = DIFF_BITS'(coord.pixel_column);
    assign py = DIFF_BITS'(coord.pixel_row);

    // stage 1: distances
    logic                 s1_valid_reg;
    logic [DIFF_BITS-1:0] s1_dx_reg;
    logic [DIFF_BITS-1:0] s1_dy_reg;
    logic [DIFF_BITS-1:0] s1_cx_reg;
    logic [DIFF_BITS-1:0] s1_cy_reg;
    // stage 2: squares
    logic                 s2_valid_reg;
    logic [SQ_BITS-1:0]   s2_dx2_reg;
    logic [SQ_BITS-1:0]   s2_dy2_reg;
    logic [SQ_BITS-1:0]   s2_cx2_reg;
    logic [SQ_BITS-1:0]   s2_cy2_reg;
    // stage 3: sums
    logic                 s3_valid_reg;
    logic [NORM_BITS-1:0] s3_d_reg;
    logic [NORM_BITS-1:0] s3_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg  <= (px >= cx) ? (px - cx) : (cx - px);
        s1_dy_reg  <= (py >= cy) ? (py - cy) : (cy - py);
        s1_cx_reg  <= cx;
        s1_cy_reg  <= cy;
        s2_dx2_reg <= s1_dx_reg * s1_dx_reg;
        s2_dy2_reg <= s1_dy_reg * s1_dy_reg;
        s2_cx2_reg <= s1_cx_reg * s1_cx_reg;
        s2_cy2_reg <= s1_cy_reg * s1_cy_reg;
        s3_d_reg   <= {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
        s3_m_reg   <= {1'b0, s2_cx2_reg} + {1'b0, s2_cy2_reg};
    end

    // stage 4: integer top bit of the quotient and saturation check
    logic [NORM_BITS+1:0] four_m;
    logic [REM_BITS-1:0]  two_m;
    logic                 hi;
    div_beat_t            prep_next;
    div_beat_t            prep_reg;

    always_comb
    begin
        four_m = {s3_m_reg, 2'b00};
        two_m  = {s3_m_reg, 1'b0};
        hi     = {1'b0, s3_d_reg} >= two_m;
        prep_next.valid = s3_valid_reg;
        prep_next.deg   = s3_m_reg == '0;
        prep_next.sat   = {2'b00, s3_d_reg} >= four_m;
        prep_next.r     = hi ? ({1'b0, s3_d_reg} - two_m) : {1'b0, s3_d_reg};
        prep_next.m     = s3_m_reg;
        prep_next.q     = {{(QUO_BITS-1){1'b0}}, hi};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg <= '0;
        else
            prep_reg <= prep_next;
    end

    div_beat_t div_chain [DIV_CELLS+1];
    assign div_chain[0] = prep_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        rwg_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (div_chain[i]),
            .dout (div_chain[i+1])
        );
    end

    sqrt_beat_t sq_chain [ROOT_BITS+1];
    sqrt_beat_t sq_first;
    div_beat_t  div_last;

    assign div_last = div_chain[DIV_CELLS];

    always_comb
    begin
        sq_first.valid = div_last.valid;
        sq_first.deg   = div_last.deg;
        sq_first.sat   = div_last.sat;
        sq_first.v     = div_last.q;
        sq_first.root  = '0;
        sq_first.rem   = '0;
        sq_first.lin   = div_last.q[QUO_BITS-1:FRAC_BITS];
    end

    assign sq_chain[0] = sq_first;

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        rwg_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (sq_chain[j]),
            .dout (sq_chain[j+1])
        );
    end

    sqrt_beat_t             sq_last;
    logic [WEIGHT_BITS-1:0] w;
    logic                   out_valid_reg;
    result_t                out_reg;

    assign sq_last = sq_chain[ROOT_BITS];

    always_comb
    begin
        if (sq_last.deg)
            w = '0;
        else if (sq_last.sat)
            w = WEIGHT_SAT;
        else if (mode_reg)
            w = (sq_last.lin > WEIGHT_SAT) ? WEIGHT_SAT : sq_last.lin;
        else
            w = WEIGHT_BITS'(sq_last.root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= sq_last.valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg.weight     <= w;
        out_reg.degenerate <= sq_last.deg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for radial_weight_generator_core: random and directed
// coordinates under several image sizes and both modes, checked by a scoreboard.
// Depends on rwg_pkg and the radial_weight_generator_core RTL.
module testbench;
    import rwg_pkg::*;

    class weight_scoreboard;
        result_t pending_weights[$];
        int mismatches;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic mode_reg;

        function new();
            mismatches = 0;
            width_reg = 13'd640;
            height_reg = 13'd480;
            mode_reg = 1'b0;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return root;
        endfunction

        function result_t weigh(coord_t c);
            result_t r;
            longint unsigned cx, cy, m, dx, dy, d, w, sat, px, py;
            px = c.pixel_column;
            py = c.pixel_row;
            cx = width_reg / 2;
            cy = height_reg / 2;
            m = cx * cx + cy * cy;
            dx = (px >= cx) ? px - cx : cx - px;
            dy = (py >= cy) ? py - cy : cy - py;
            d = dx * dx + dy * dy;
            sat = 64'd2 << FRAC_BITS;
            r.degenerate = 1'b0;
            if (m == 0)
            begin
                r.weight = '0;
                r.degenerate = 1'b1;
                return r;
            end
            if (mode_reg)
                w = (d >= 2 * m) ? sat : (d << FRAC_BITS) / m;
            else
                w = (d >= 4 * m) ? sat : floor_root((d << (2 * FRAC_BITS)) / m);
            if (w > sat) w = sat;
            r.weight = w[WEIGHT_BITS-1:0];
            return r;
        endfunction

        function void note_coord(coord_t c);
            pending_weights = {pending_weights, weigh(c)};
        endfunction

        function void check_weight(result_t got);
            result_t want;
            if (pending_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result weight=%0d degenerate=%0b",
                             got.weight, got.degenerate);
                return;
            end
            want = pending_weights.pop_front();
            if (got.weight !== want.weight || got.degenerate !== want.degenerate)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected weight=%0d degenerate=%0b, got %0d %0b",
                             want.weight, want.degenerate, got.weight, got.degenerate);
            end
        endfunction
    endclass

    localparam int LATENCY = 2 * FRAC_BITS + FRAC_BITS + 7;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    coord_t coord = '0;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    weight_scoreboard board = new();
    int idle_cycles = 0;
    bit quiet_phase = 0;

    radial_weight_generator_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .coord(coord),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_weight(result);
        if (rst_n && ((start && !busy) || (cfg_valid && cfg_ready) || result_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH) board.width_reg = val;
        else if (idx == REG_IMAGE_HEIGHT) board.height_reg = val;
        else if (idx == REG_DISTANCE_MODE) board.mode_reg = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int w, int h, int m);
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(h));
        write_reg(REG_DISTANCE_MODE, CFG_BITS'(m));
    endtask

    task automatic send_coord(coord_t c);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        coord <= c;
        do @(posedge clk); while (busy);
        board.note_coord(c);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (board.pending_weights.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_coords(int n);
        coord_t c;
        int cx, cy;
        for (int i = 0; i < n; i++)
        begin
            cx = board.width_reg / 2;
            cy = board.height_reg / 2;
            if ($urandom_range(0, 3) == 0)
                c = coord_t'(24'($urandom));
            else
            begin
                c.pixel_column = 12'($urandom_range(0, (board.width_reg > 4096) ? 4095 :
                    (board.width_reg == 0 ? 0 : board.width_reg - 1)));
                c.pixel_row = 12'($urandom_range(0, (board.height_reg > 4096) ? 4095 :
                    (board.height_reg == 0 ? 0 : board.height_reg - 1)));
                if ($urandom_range(0, 7) == 0)
                begin
                    c.pixel_column = cx[11:0];
                    c.pixel_row = cy[11:0];
                end
            end
            send_coord(c);
        end
    endtask

    initial
    begin
        coord_t c;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        c.pixel_column = 12'd320; c.pixel_row = 12'd240; send_coord(c);
        c.pixel_column = 12'd0;   c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'd639; c.pixel_row = 12'd479; send_coord(c);
        c.pixel_column = 12'hFFF; c.pixel_row = 12'hFFF; send_coord(c);
        c.pixel_column = 12'hFFF; c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'd0;   c.pixel_row = 12'hFFF; send_coord(c);
        c.pixel_column = 12'd321; c.pixel_row = 12'd240; send_coord(c);
        drain();

        configure(640, 480, 1);
        c.pixel_column = 12'd0;   c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'hFFF; c.pixel_row = 12'hFFF; send_coord(c);
        c.pixel_column = 12'd320; c.pixel_row = 12'd241; send_coord(c);
        drain();

        configure(1, 1, 0);
        c.pixel_column = 12'd0;   c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'hABC; c.pixel_row = 12'h543; send_coord(c);
        drain();

        configure(0, 8191, 1);
        c.pixel_column = 12'd0;   c.pixel_row = 12'hFFF; send_coord(c);
        c.pixel_column = 12'h800; c.pixel_row = 12'h555; send_coord(c);
        drain();

        configure(4096, 4096, 0);
        c.pixel_column = 12'd0;   c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'hFFF; c.pixel_row = 12'hFFF; send_coord(c);
        c.pixel_column = 12'h800; c.pixel_row = 12'h800; send_coord(c);
        drain();

        configure(2, 1, 0);
        c.pixel_column = 12'd0;   c.pixel_row = 12'd0;   send_coord(c);
        c.pixel_column = 12'd1;   c.pixel_row = 12'd0;   send_coord(c);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase % 3)
                0: configure($urandom_range(1, 64), $urandom_range(1, 64), phase & 1);
                1: configure($urandom_range(1, 4096), $urandom_range(1, 4096), phase & 1);
                default: configure($urandom_range(0, 8191), $urandom_range(0, 8191),
                                   $urandom_range(0, 1));
            endcase
            if (phase == 8) quiet_phase = 1;
            random_coords(100);
            drain();
        end

        if (board.mismatches == 0 && board.pending_weights.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/rwg_pkg.sv
hw/rtl/rwg_div_cell.sv
hw/rtl/rwg_sqrt_cell.sv
hw/rtl/radial_weight_generator_core.sv
tb/testbench.sv
